// ===== design/pig_pkg.sv =====
// Package for the primitive index generator.
// Holds type codes, list codes, sizes and the command record passed front to back.
// No dependencies.
package pig_pkg;

   localparam logic [15:0] INDEX_CEILING = 16'd65534;
   localparam logic [15:0] RESTART_MARK  = 16'hFFFF;

   localparam int MAX_RESULTS = 6;
   localparam int CNT_W       = $clog2(MAX_RESULTS + 1);
   localparam int IDX_W       = $clog2(MAX_RESULTS);

   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   typedef enum logic {
      OP_BATCH_START = 1'b0,
      OP_VERTEX      = 1'b1
   } op_type;

   typedef enum logic [2:0] {
      PRIM_QUADS      = 3'd0,
      PRIM_NONE       = 3'd1,
      PRIM_TRI_LIST   = 3'd2,
      PRIM_STRIP      = 3'd3,
      PRIM_FAN        = 3'd4,
      PRIM_LINE_LIST  = 3'd5,
      PRIM_LINE_STRIP = 3'd6,
      PRIM_POINTS     = 3'd7
   } prim_type_type;

   localparam logic [1:0] LIST_TRIANGLE = 2'd0;
   localparam logic [1:0] LIST_LINE     = 2'd1;
   localparam logic [1:0] LIST_POINT    = 2'd2;

   typedef struct packed {
      logic [1:0]                    target_list;
      logic [CNT_W-1:0]              count;
      logic [MAX_RESULTS-1:0][15:0]  index_value;
      logic [31:0]                   triangles_total;
      logic [31:0]                   lines_total;
      logic [31:0]                   points_total;
      logic [15:0]                   remaining_indices;
   } cmd_type;

   typedef struct packed {
      logic push;
      logic full;
   } qctl_type;

endpackage

// ===== design/pig_req_if.sv =====
// Vertex request channel: valid/ready handshake with the vertex payload.
// No dependencies.
interface pig_req_if;
   logic        valid;
   logic        ready;
   logic        opcode;
   logic [2:0]  primitive_type;
   logic [15:0] vertex_count;

   modport source (output valid, opcode, primitive_type, vertex_count, input ready);
   modport sink   (input valid, opcode, primitive_type, vertex_count, output ready);
endinterface

// ===== design/pig_rsp_if.sv =====
// Index response channel: valid/ready handshake with one index and running totals.
// No dependencies.
interface pig_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  target_list;
   logic [15:0] index_value;
   logic        last;
   logic [31:0] triangles_total;
   logic [31:0] lines_total;
   logic [31:0] points_total;
   logic [15:0] remaining_indices;

   modport source (output valid, target_list, index_value, last, triangles_total,
                   lines_total, points_total, remaining_indices, input ready);
   modport sink   (input valid, target_list, index_value, last, triangles_total,
                   lines_total, points_total, remaining_indices, output ready);
endinterface

// ===== design/pig_front.sv =====
// Front end: accepts vertices, tracks primitive state and counts, builds index commands.
// Depends on pig_pkg and pig_req_if.
module pig_front
   import pig_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   pig_req_if.sink       req_ch,
   input  logic          csr_write_enable,
   input  logic          csr_write_data,
   input  logic          q_full,
   output qctl_type      qctl,
   output cmd_type       cmd
);

   logic [15:0] base_ff, base_in;
   logic [15:0] pos_ff, pos_in;
   logic [1:0]  mod3_ff, mod3_in;
   logic [31:0] tri_ff, tri_in;
   logic [31:0] line_ff, line_in;
   logic [31:0] point_ff, point_in;
   logic        restart_ff;

   logic                         accept;
   logic                         is_vertex;
   logic                         in_range;
   logic                         prim_end;
   logic                         is_final;
   logic                         pr;
   logic [15:0]                  n;
   logic [15:0]                  pm1, pm2, pm3;
   logic [MAX_RESULTS-1:0][15:0] off;
   logic [MAX_RESULTS-1:0]       mark;
   logic [CNT_W-1:0]             cnt;
   logic [1:0]                   list;
   logic [15:0]                  tri_inc;
   logic                         line_inc;
   logic                         point_inc;
   logic [15:0]                  base_next;
   prim_type_type                ptype;

   assign req_ch.ready = !q_full;
   assign accept       = req_ch.valid && req_ch.ready;
   assign is_vertex    = req_ch.opcode == OP_VERTEX;
   assign n            = req_ch.vertex_count;
   assign ptype        = prim_type_type'(req_ch.primitive_type);
   assign pr           = restart_ff;
   assign pm1          = pos_ff - 16'd1;
   assign pm2          = pos_ff - 16'd2;
   assign pm3          = pos_ff - 16'd3;
   assign in_range     = pos_ff < n;
   assign prim_end     = ({1'b0, pos_ff} + 17'd1) >= {1'b0, n};
   assign is_final     = pos_ff == n - 16'd1;
   assign base_next    = prim_end ? base_ff + n : base_ff;

   always_comb begin
      off       = '0;
      mark      = '0;
      cnt       = '0;
      list      = LIST_TRIANGLE;
      tri_inc   = '0;
      line_inc  = 1'b0;
      point_inc = 1'b0;
      if (in_range) begin
         case (ptype)
            PRIM_QUADS: begin
               if (pos_ff[1:0] == 2'd3) begin
                  tri_inc = 16'd2;
                  if (pr) begin
                     off[0] = pm2; off[1] = pm1; off[2] = pm3; off[3] = pos_ff;
                     mark[4] = 1'b1;
                     cnt = CNT_W'(5);
                  end else begin
                     off[0] = pm3; off[1] = pm2; off[2] = pm1;
                     off[3] = pm3; off[4] = pm1; off[5] = pos_ff;
                     cnt = CNT_W'(6);
                  end
               end else if (is_final && n[1:0] == 2'd3) begin
                  off[0] = pm2; off[1] = pm1; off[2] = pos_ff;
                  mark[3] = pr;
                  cnt = pr ? CNT_W'(4) : CNT_W'(3);
                  tri_inc = 16'd1;
               end
            end
            PRIM_TRI_LIST: begin
               if (mod3_ff == 2'd2) begin
                  off[0] = pm2; off[1] = pm1; off[2] = pos_ff;
                  mark[3] = pr;
                  cnt = pr ? CNT_W'(4) : CNT_W'(3);
                  tri_inc = 16'd1;
               end
            end
            PRIM_STRIP: begin
               if (pr) begin
                  off[0] = pos_ff;
                  cnt = CNT_W'(1);
                  if (is_final) begin
                     mark[1] = 1'b1;
                     cnt = CNT_W'(2);
                     tri_inc = (n >= 16'd2) ? n - 16'd2 : 16'd0;
                  end
               end else if (pos_ff >= 16'd2) begin
                  off[0] = pm2;
                  off[1] = pos_ff[0] ? pos_ff : pm1;
                  off[2] = pos_ff[0] ? pm1 : pos_ff;
                  cnt = CNT_W'(3);
                  tri_inc = 16'd1;
               end
            end
            PRIM_FAN: begin
               if (pr) begin
                  if (pos_ff >= 16'd4 && mod3_ff == 2'd1) begin
                     off[0] = pm3; off[1] = pm2; off[2] = 16'd0;
                     off[3] = pm1; off[4] = pos_ff; mark[5] = 1'b1;
                     cnt = CNT_W'(6);
                     tri_inc = 16'd3;
                  end else if (is_final && n >= 16'd2 && mod3_ff == 2'd0) begin
                     off[0] = pm2; off[1] = pm1; off[2] = 16'd0;
                     off[3] = pos_ff; mark[4] = 1'b1;
                     cnt = CNT_W'(5);
                     tri_inc = 16'd2;
                  end else if (is_final && n >= 16'd2 && mod3_ff == 2'd2) begin
                     off[0] = 16'd0; off[1] = pm1; off[2] = pos_ff; mark[3] = 1'b1;
                     cnt = CNT_W'(4);
                     tri_inc = 16'd1;
                  end
               end else if (pos_ff >= 16'd2) begin
                  off[0] = 16'd0; off[1] = pm1; off[2] = pos_ff;
                  cnt = CNT_W'(3);
                  tri_inc = 16'd1;
               end
            end
            PRIM_LINE_LIST: begin
               if (pos_ff[0]) begin
                  off[0] = pm1; off[1] = pos_ff;
                  list = LIST_LINE;
                  cnt = CNT_W'(2);
                  line_inc = 1'b1;
               end
            end
            PRIM_LINE_STRIP: begin
               if (pos_ff >= 16'd1) begin
                  off[0] = pm1; off[1] = pos_ff;
                  list = LIST_LINE;
                  cnt = CNT_W'(2);
                  line_inc = 1'b1;
               end
            end
            PRIM_POINTS: begin
               off[0] = pos_ff;
               list = LIST_POINT;
               cnt = CNT_W'(1);
               point_inc = 1'b1;
            end
            default: begin
               cnt = '0;
            end
         endcase
      end
   end

   always_comb begin
      tri_in   = tri_ff + {16'd0, tri_inc};
      line_in  = line_ff + {31'd0, line_inc};
      point_in = point_ff + {31'd0, point_inc};
      base_in  = base_next;
      if (prim_end) begin
         pos_in  = '0;
         mod3_in = '0;
      end else begin
         pos_in  = pos_ff + 16'd1;
         mod3_in = (mod3_ff == 2'd2) ? 2'd0 : mod3_ff + 2'd1;
      end
   end

   always_comb begin
      cmd.target_list       = list;
      cmd.count             = cnt;
      cmd.triangles_total   = tri_in;
      cmd.lines_total       = line_in;
      cmd.points_total      = point_in;
      cmd.remaining_indices = (base_next >= INDEX_CEILING) ? 16'd0
                                                           : INDEX_CEILING - base_next;
      for (int i = 0; i < MAX_RESULTS; i++) begin
         cmd.index_value[i] = mark[i] ? RESTART_MARK : base_ff + off[i];
      end
   end

   assign qctl.push = accept && is_vertex && cnt != '0;
   assign qctl.full = q_full;

   always_ff @(posedge clock) begin
      if (reset) begin
         restart_ff <= 1'b0;
      end else if (csr_write_enable) begin
         restart_ff <= csr_write_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff  <= '0;
         pos_ff   <= '0;
         mod3_ff  <= '0;
         tri_ff   <= '0;
         line_ff  <= '0;
         point_ff <= '0;
      end else if (accept) begin
         if (is_vertex) begin
            base_ff  <= base_in;
            pos_ff   <= pos_in;
            mod3_ff  <= mod3_in;
            tri_ff   <= tri_in;
            line_ff  <= line_in;
            point_ff <= point_in;
         end else begin
            base_ff  <= '0;
            pos_ff   <= '0;
            mod3_ff  <= '0;
            tri_ff   <= '0;
            line_ff  <= '0;
            point_ff <= '0;
         end
      end
   end

   assert property (@(posedge clock) disable iff (reset)
      mod3_ff != 2'd3)
      else $error("position residue out of range");

   assert property (@(posedge clock) disable iff (reset)
      (accept && is_vertex && !prim_end) |=> pos_ff == $past(pos_ff) + 16'd1)
      else $error("position did not advance");

endmodule

// ===== design/pig_queue.sv =====
// Command queue between the front end and the index sequencer.
// Depends on pig_pkg.
module pig_queue
   import pig_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     push,
   input  cmd_type  push_data,
   input  logic     pop,
   output cmd_type  head,
   output logic     empty,
   output logic     full
);

   cmd_type             ent_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff;
   logic [QPTR_W-1:0]   rd_ptr_ff;
   logic [QCNT_W-1:0]   count_ff;

   assign empty = count_ff == '0;
   assign full  = count_ff == QCNT_W'(QUEUE_DEPTH);
   assign head  = ent_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (push) begin
         ent_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + QPTR_W'(1);
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + QPTR_W'(1);
         end
         if (push && !pop) begin
            count_ff <= count_ff + QCNT_W'(1);
         end else if (pop && !push) begin
            count_ff <= count_ff - QCNT_W'(1);
         end
      end
   end

   assert property (@(posedge clock) disable iff (reset)
      count_ff <= QCNT_W'(QUEUE_DEPTH))
      else $error("queue count overflow");

   assert property (@(posedge clock) disable iff (reset)
      push |-> !full)
      else $error("push into full queue");

   assert property (@(posedge clock) disable iff (reset)
      pop |-> !empty)
      else $error("pop from empty queue");

endmodule

// ===== design/pig_back.sv =====
// Index sequencer: walks the head command one index per cycle into the output register
// while that register is empty or being taken. Depends on pig_pkg and pig_rsp_if.
module pig_back
   import pig_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  cmd_type       head,
   input  logic          empty,
   output logic          pop,
   pig_rsp_if.source     rsp_ch
);

   logic [IDX_W-1:0] k_ff;
   logic             rsp_valid_ff;
   logic [1:0]       list_ff;
   logic [15:0]      value_ff;
   logic             last_ff;
   logic [31:0]      tri_ff;
   logic [31:0]      line_ff;
   logic [31:0]      point_ff;
   logic [15:0]      rem_ff;
   logic             load;
   logic             is_last;

   assign load    = !empty && (!rsp_valid_ff || rsp_ch.ready);
   assign is_last = k_ff == IDX_W'(head.count - CNT_W'(1));
   assign pop     = load && is_last;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         k_ff         <= '0;
      end else begin
         if (load) begin
            rsp_valid_ff <= 1'b1;
            k_ff         <= is_last ? '0 : k_ff + IDX_W'(1);
         end else if (rsp_ch.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         list_ff  <= head.target_list;
         value_ff <= head.index_value[k_ff];
         last_ff  <= is_last;
         tri_ff   <= head.triangles_total;
         line_ff  <= head.lines_total;
         point_ff <= head.points_total;
         rem_ff   <= head.remaining_indices;
      end
   end

   assign rsp_ch.valid             = rsp_valid_ff;
   assign rsp_ch.target_list       = list_ff;
   assign rsp_ch.index_value       = value_ff;
   assign rsp_ch.last              = last_ff;
   assign rsp_ch.triangles_total   = tri_ff;
   assign rsp_ch.lines_total       = line_ff;
   assign rsp_ch.points_total      = point_ff;
   assign rsp_ch.remaining_indices = rem_ff;

   assert property (@(posedge clock) disable iff (reset)
      !empty |-> ({1'b0, k_ff} < {1'b0, head.count}))
      else $error("sequencer index past command length");

endmodule

// ===== design/primitive_index_generator_top.sv =====
// Path: the first index of a vertex passes through its command queue entry, then the output register.
// Throughput: one vertex per cycle into a 4-entry command queue while the queue is not full;
// the single output register drains one index per cycle while rsp_ch is ready and a command waits.
// Reset: synchronous, active high; clears base, position, counts, restart enable and queue.
// Top level of the primitive index generator; depends on pig_pkg, pig_req_if,
// pig_rsp_if, pig_front, pig_queue and pig_back.
module primitive_index_generator_top
   import pig_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   pig_req_if.sink    req_ch,
   pig_rsp_if.source  rsp_ch,
   input  logic       csr_write_enable,
   input  logic       csr_write_data
);

   qctl_type qctl;
   cmd_type  cmd;
   cmd_type  head;
   logic     q_empty;
   logic     q_full;
   logic     q_pop;

   pig_front u_front (
      .clock            (clock),
      .reset            (reset),
      .req_ch           (req_ch),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .q_full           (q_full),
      .qctl             (qctl),
      .cmd              (cmd)
   );

   pig_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (qctl.push),
      .push_data (cmd),
      .pop       (q_pop),
      .head      (head),
      .empty     (q_empty),
      .full      (q_full)
   );

   pig_back u_back (
      .clock  (clock),
      .reset  (reset),
      .head   (head),
      .empty  (q_empty),
      .pop    (q_pop),
      .rsp_ch (rsp_ch)
   );

endmodule
